// ===== rtl/smx_pkg.sv =====
// Shared types, constants and helper functions for the saturating audio mixer.
// No dependencies; imported by every module of the block.
package smx_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int CHANNEL_W      = 3;
    localparam int CHANNELS       = 8;
    localparam int GAIN_W         = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int FMT_W          = 2;
    localparam int ACC_W          = 38;
    localparam int PROD_W         = SAMPLE_W + GAIN_W + 1;
    localparam int TERM_W         = PROD_W - GAIN_FRAC_BITS;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = GAIN_W;

    localparam logic [FMT_W-1:0] FMT_8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_16 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_32 = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN          = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MUTE_MASK     = 2'd2;

    localparam logic [FMT_W-1:0]    SAMPLE_FORMAT_RESET = FMT_16;
    localparam logic [GAIN_W-1:0]   GAIN_RESET          = 24'h010000;
    localparam logic [CHANNELS-1:0] MUTE_MASK_RESET     = '0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CHANNEL_W-1:0]       channel;
        logic                       last_source;
    } src_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed_sample;
        logic [CHANNEL_W-1:0]       out_channel;
    } mix_item_t;

    typedef struct packed {
        logic [FMT_W-1:0]    sample_format;
        logic [GAIN_W-1:0]   gain;
        logic [CHANNELS-1:0] mute_mask;
    } cfg_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic [CHANNEL_W-1:0]     channel;
        logic                     last_source;
    } prod_stage_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] term;
        logic [CHANNEL_W-1:0]       channel;
        logic                       last_source;
    } term_stage_t;

    // Sign-extend the low 8, 16 or 32 bits of a sample; the unused code acts as 32-bit.
    function automatic logic signed [SAMPLE_W-1:0] fmt_sext(
        input logic [SAMPLE_W-1:0] s,
        input logic [FMT_W-1:0]    fmt
    );
        logic signed [SAMPLE_W-1:0] r;
        unique case (fmt)
            FMT_8:   r = {{(SAMPLE_W-8){s[7]}}, s[7:0]};
            FMT_16:  r = {{(SAMPLE_W-16){s[15]}}, s[15:0]};
            default: r = s;
        endcase
        return r;
    endfunction

    // Clamp a wide signed value to the configured sample range.
    function automatic logic signed [SAMPLE_W-1:0] fmt_clamp(
        input logic signed [TERM_W-1:0] v,
        input logic [FMT_W-1:0]         fmt
    );
        logic signed [TERM_W-1:0] hi;
        logic signed [TERM_W-1:0] lo;
        logic signed [TERM_W-1:0] r;
        unique case (fmt)
            FMT_8:   hi = {{(TERM_W-8){1'b0}}, 8'h7F};
            FMT_16:  hi = {{(TERM_W-16){1'b0}}, 16'h7FFF};
            default: hi = {{(TERM_W-32){1'b0}}, 32'h7FFF_FFFF};
        endcase
        lo = ~hi;
        if (v > hi)
            r = hi;
        else if (v < lo)
            r = lo;
        else
            r = v;
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== rtl/smx_cfg_regs.sv =====
// Configuration registers: sample format, master gain and per-channel mute mask.
// Depends on smx_pkg.
module smx_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [smx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [smx_pkg::CFG_DATA_W-1:0]   cfg_data,
    output smx_pkg::cfg_t                    cfg
);
    import smx_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_format <= SAMPLE_FORMAT_RESET;
            cfg_reg.gain          <= GAIN_RESET;
            cfg_reg.mute_mask     <= MUTE_MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_FORMAT: cfg_reg.sample_format <= cfg_data[FMT_W-1:0];
                REG_GAIN:          cfg_reg.gain          <= cfg_data[GAIN_W-1:0];
                REG_MUTE_MASK:     cfg_reg.mute_mask     <= cfg_data[CHANNELS-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/smx_mul.sv =====
// Input register and gain multiply: sign-extends by format, applies gain or mute,
// registers the full product. Depends on smx_pkg.
module smx_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  src_valid,
    input  smx_pkg::src_item_t    src,
    input  smx_pkg::cfg_t         cfg,
    output logic                  prod_valid,
    output smx_pkg::prod_stage_t  prod_stage
);
    import smx_pkg::*;

    logic                       in_valid_reg;
    src_item_t                  in_reg;
    logic                       prod_valid_reg;
    prod_stage_t                prod_reg;
    logic signed [SAMPLE_W-1:0] s_ext;
    logic [GAIN_W-1:0]          g;
    prod_stage_t                prod_next;

    always_comb
    begin
        s_ext = fmt_sext(in_reg.sample, cfg.sample_format);
        g     = cfg.mute_mask[in_reg.channel] ? '0 : cfg.gain;
        prod_next.prod        = PROD_W'(s_ext) * $signed(PROD_W'({1'b0, g}));
        prod_next.channel     = in_reg.channel;
        prod_next.last_source = in_reg.last_source;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg   <= src_valid;
            prod_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg   <= src;
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod_stage = prod_reg;

endmodule

// ===== rtl/smx_scale.sv =====
// Scale stage: drops the gain fraction bits with truncation toward zero and
// clamps the term to the sample range. Depends on smx_pkg.
module smx_scale (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  prod_valid,
    input  smx_pkg::prod_stage_t  prod_stage,
    input  smx_pkg::cfg_t         cfg,
    output logic                  term_valid,
    output smx_pkg::term_stage_t  term_stage
);
    import smx_pkg::*;

    logic                     term_valid_reg;
    term_stage_t              term_reg;
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] biased;
    term_stage_t              term_next;

    always_comb
    begin
        // negative products round toward zero: add 2^frac - 1 before the shift
        bias   = $signed({{(PROD_W-GAIN_FRAC_BITS){1'b0}},
                          {GAIN_FRAC_BITS{prod_stage.prod[PROD_W-1]}}});
        biased = prod_stage.prod + bias;
        term_next.term        = fmt_clamp(biased[PROD_W-1:GAIN_FRAC_BITS], cfg.sample_format);
        term_next.channel     = prod_stage.channel;
        term_next.last_source = prod_stage.last_source;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_valid_reg <= 1'b0;
        else if (en)
            term_valid_reg <= prod_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            term_reg <= term_next;
    end

    assign term_valid = term_valid_reg;
    assign term_stage = term_reg;

endmodule

// ===== rtl/smx_accum.sv =====
// Saturating accumulator and output register; emits the clamped sum on the
// last source of a frame and clears. Depends on smx_pkg.
module smx_accum (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  term_valid,
    input  smx_pkg::term_stage_t  term_stage,
    input  smx_pkg::cfg_t         cfg,
    output logic                  mix_valid,
    output smx_pkg::mix_item_t    mix
);
    import smx_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic                    mix_valid_reg;
    mix_item_t               mix_reg;
    mix_item_t               mix_next;

    always_comb
    begin
        sum = {acc_reg[ACC_W-1], acc_reg}
            + {{(ACC_W+1-SAMPLE_W){term_stage.term[SAMPLE_W-1]}}, term_stage.term};
        if (sum[ACC_W] != sum[ACC_W-1])
            acc_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            acc_sat = sum[ACC_W-1:0];

        mix_next.mixed_sample = fmt_clamp({{(TERM_W-ACC_W){acc_sat[ACC_W-1]}}, acc_sat},
                                          cfg.sample_format);
        mix_next.out_channel  = term_stage.channel;

        if (term_valid)
            acc_next = term_stage.last_source ? '0 : acc_sat;
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            mix_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            acc_reg       <= acc_next;
            mix_valid_reg <= term_valid && term_stage.last_source;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && term_valid && term_stage.last_source)
            mix_reg <= mix_next;
    end

    assign mix_valid = mix_valid_reg;
    assign mix       = mix_reg;

endmodule

// ===== rtl/saturating_audio_mixer_core.sv =====
// Saturating audio mixer: one source sample per transaction is gained, clamped
// and summed; the last source of a frame produces one mixed sample.
// Depends on smx_pkg, smx_cfg_regs, smx_mul, smx_scale, smx_accum.
//
// The mixer takes one source transaction per clock while src_ready is high. A
// mixed sample reaches the output register after its last source passes the
// input register, the 32x25 gain multiply, truncate-and-clamp, then the
// saturating accumulator and output register. Only transactions flagged
// last_source produce a result; all others just add into the shared
// accumulator. The whole pipeline holds while a result waits in the output
// register and mix_ready is low. Configuration writes take effect immediately
// and must be made only while the mixer is idle.
module saturating_audio_mixer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             src_valid,
    output logic                             src_ready,
    input  smx_pkg::src_item_t               src,
    output logic                             mix_valid,
    input  logic                             mix_ready,
    output smx_pkg::mix_item_t               mix,
    input  logic                             cfg_we,
    input  logic [smx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [smx_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import smx_pkg::*;

    cfg_t        cfg;
    logic        en;
    logic        prod_valid;
    prod_stage_t prod_stage;
    logic        term_valid;
    term_stage_t term_stage;

    assign en        = !mix_valid || mix_ready;
    assign src_ready = en;

    smx_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smx_mul u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .src_valid  (src_valid),
        .src        (src),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod_stage (prod_stage)
    );

    smx_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .prod_valid (prod_valid),
        .prod_stage (prod_stage),
        .cfg        (cfg),
        .term_valid (term_valid),
        .term_stage (term_stage)
    );

    smx_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .term_valid (term_valid),
        .term_stage (term_stage),
        .cfg        (cfg),
        .mix_valid  (mix_valid),
        .mix        (mix)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for saturating_audio_mixer_core: a scoreboard class predicts
// each mixed sample from the accepted source transactions and checks the result stream.
// Depends on smx_pkg and the mixer RTL; no files or arguments are read.
module tb_top;
    import smx_pkg::*;

    localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES = 10;
    localparam int PHASE_SOURCES = 150;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_mode_t;

    class mix_scoreboard;
        localparam longint ACC_TOP = (longint'(1) <<< (ACC_W - 1)) - 1;
        localparam longint ACC_BOTTOM = -ACC_TOP - 1;

        logic [FMT_W-1:0]    fmt;
        logic [GAIN_W-1:0]   gain;
        logic [CHANNELS-1:0] mute;
        longint              acc;
        mix_item_t           pending_mix[$];
        int                  errors;
        int                  sources;
        int                  mixes;
        int                  settings;

        function new();
            fmt = SAMPLE_FORMAT_RESET;
            gain = GAIN_RESET;
            mute = MUTE_MASK_RESET;
            acc = 0;
            errors = 0;
            sources = 0;
            mixes = 0;
            settings = 1;
        endfunction

        function longint clamp_to(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SAMPLE_FORMAT: fmt = data[FMT_W-1:0];
                REG_GAIN:          gain = data[GAIN_W-1:0];
                REG_MUTE_MASK:     mute = data[CHANNELS-1:0];
                default: ;
            endcase
        endfunction

        // Gain, truncate toward zero, clamp to width, then saturating accumulate.
        function void predict_source(src_item_t item);
            int unsigned width_bits;
            longint      hi;
            longint      lo;
            longint      smp;
            longint      term;
            mix_item_t   m;
            case (fmt)
                FMT_8:
                begin
                    width_bits = 8;
                    smp = longint'($signed(item.sample[7:0]));
                end
                FMT_16:
                begin
                    width_bits = 16;
                    smp = longint'($signed(item.sample[15:0]));
                end
                default:
                begin
                    width_bits = 32;
                    smp = longint'($signed(item.sample));
                end
            endcase
            hi = (longint'(1) <<< (width_bits - 1)) - 1;
            lo = -hi - 1;
            term = mute[item.channel] ? 0 : smp * longint'(gain);
            term = term / (longint'(1) <<< GAIN_FRAC_BITS);
            term = clamp_to(term, lo, hi);
            acc = clamp_to(acc + term, ACC_BOTTOM, ACC_TOP);
            sources++;
            if (item.last_source)
            begin
                m.mixed_sample = 32'(clamp_to(acc, lo, hi));
                m.out_channel = item.channel;
                pending_mix.insert(pending_mix.size(), m);
                acc = 0;
            end
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_mix(mix_item_t got);
            mix_item_t want;
            if (pending_mix.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected mix %0d on channel %0d",
                                        got.mixed_sample, got.out_channel));
                return;
            end
            want = pending_mix[0];
            pending_mix.delete(0);
            mixes++;
            if (got.mixed_sample !== want.mixed_sample)
                flag_mismatch($sformatf("mixed_sample got %0d want %0d (result %0d)",
                                        got.mixed_sample, want.mixed_sample, mixes));
            if (got.out_channel !== want.out_channel)
                flag_mismatch($sformatf("out_channel got %0d want %0d (result %0d)",
                                        got.out_channel, want.out_channel, mixes));
        endtask

        task check_leftover();
            while (pending_mix.size() != 0)
            begin
                flag_mismatch($sformatf("mix on channel %0d never arrived",
                                        pending_mix[0].out_channel));
                pending_mix.delete(0);
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   src_valid = 1'b0;
    logic                   src_ready;
    src_item_t              src = '0;
    logic                   mix_valid;
    logic                   mix_ready = 1'b0;
    mix_item_t              mix;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    mix_scoreboard sb = new();
    int unsigned   cycle_count = 0;
    ready_mode_t   ready_mode = READY_ALWAYS;
    int unsigned   mode_left = 0;
    int            burst_left = 0;

    saturating_audio_mixer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src       (src),
        .mix_valid (mix_valid),
        .mix_ready (mix_ready),
        .mix       (mix),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(50, 300);
        end
        else
            mode_left <= mode_left - 1;
        case (ready_mode)
            READY_ALWAYS:   mix_ready <= 1'b1;
            READY_MOSTLY:   mix_ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY:   mix_ready <= ($urandom_range(0, 3) == 0);
            default:        mix_ready <= ((cycle_count % 9) < 4);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && src_ready)
                sb.predict_source(src);
            if (mix_valid && mix_ready)
                sb.check_mix(mix);
        end
    end

    task automatic push_source(input logic [SAMPLE_W-1:0] smp, input logic [CHANNEL_W-1:0] ch,
                               input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        src_valid <= 1'b1;
        src <= '{sample: smp, channel: ch, last_source: last};
        @(posedge clk);
        while (!src_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        src_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_mix.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(input logic [FMT_W-1:0] fmt_v, input logic [GAIN_W-1:0] gain_v,
                             input logic [CHANNELS-1:0] mute_v);
        drain_results();
        write_reg(REG_SAMPLE_FORMAT, CFG_DATA_W'(fmt_v));
        write_reg(REG_GAIN, CFG_DATA_W'(gain_v));
        write_reg(REG_MUTE_MASK, CFG_DATA_W'(mute_v));
        cfg_we <= 1'b0;
        sb.settings++;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom_range(0, 24'h03_FFFF));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: ;
            1:
                case ($urandom_range(0, 7))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_007F;
                    3: v = 32'hFFFF_FF80;
                    4: v = 32'h0000_7FFF;
                    5: v = 32'hFFFF_8000;
                    6: v = 32'hFFFF_FFFF;
                    default: v = '0;
                endcase
            default:
                case (sb.fmt)
                    FMT_8:  v = {{24{v[7]}}, v[7:0]};
                    FMT_16: v = {{16{v[15]}}, v[15:0]};
                    default: ;
                endcase
        endcase
        return v;
    endfunction

    // loud: full-scale samples of one sign, to drive the accumulator toward saturation
    task automatic mix_frame(input int n_src, input bit blend, input bit loud);
        logic [CHANNEL_W-1:0] ch;
        logic [SAMPLE_W-1:0]  full_scale;
        ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
        full_scale = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        for (int i = 0; i < n_src; i++)
        begin
            if (blend)
                ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
            push_source(loud ? full_scale : pick_sample(), ch, i == n_src - 1);
        end
    endtask

    initial
    begin
        int phase_items;
        int n_src;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 16-bit, unity gain, nothing muted
        push_source(32'h0000_7FFF, 3'd0, 1'b1);
        push_source(32'h0000_7FFF, 3'd1, 1'b0);
        push_source(32'h0000_7FFF, 3'd1, 1'b1);
        push_source(32'hFFFF_8000, 3'd2, 1'b0);
        push_source(32'hFFFF_8000, 3'd2, 1'b1);
        push_source(32'h7FFF_FFFF, 3'd3, 1'b1);
        push_source(32'h8000_0000, 3'd4, 1'b1);
        push_source(32'h0001_2345, 3'd5, 1'b0);
        push_source(32'h0000_0001, 3'd6, 1'b1);
        push_source(32'hFFFF_FFFF, 3'd7, 1'b1);
        push_source(32'h0000_0000, 3'd0, 1'b1);

        // 8-bit, gain 1.5, top channel muted
        configure(FMT_8, 24'h01_8000, 8'h80);
        push_source(32'h0000_007F, 3'd0, 1'b1);
        push_source(32'h0000_00FD, 3'd1, 1'b1);
        push_source(32'h0000_0055, 3'd7, 1'b1);
        push_source(32'h1234_5680, 3'd2, 1'b1);

        // spare format code with maximum gain
        configure(FMT_SPARE, 24'hFF_FFFF, 8'h00);
        push_source(32'h7FFF_FFFF, 3'd0, 1'b1);
        push_source(32'h8000_0000, 3'd1, 1'b1);
        push_source(32'h0000_0001, 3'd2, 1'b1);
        push_source(32'hFFFF_FFFF, 3'd3, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       configure(FMT_32, 24'hFF_FFFF, 8'h00);
                1:       configure(FMT_8, 24'h00_0000, 8'hFF);
                2:       configure(FMT_SPARE, GAIN_RESET, 8'h55);
                3:       configure(FMT_16, pick_gain(), CHANNELS'($urandom));
                4:       configure(FMT_8, 24'hFF_FFFF, 8'h00);
                default: configure(FMT_W'($urandom_range(0, 3)), pick_gain(),
                                   CHANNELS'($urandom));
            endcase
            phase_items = 0;
            if (sb.fmt == FMT_32 || sb.fmt == FMT_SPARE)
            begin
                n_src = $urandom_range(66, 72);
                mix_frame(n_src, 1'b0, 1'b1);
                phase_items += n_src;
            end
            while (phase_items < PHASE_SOURCES)
            begin
                n_src = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24)
                                                    : $urandom_range(1, 16);
                mix_frame(n_src, $urandom_range(0, 5) == 0, $urandom_range(0, 59) == 0);
                phase_items += n_src;
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
        end

        drain_results();
        sb.check_leftover();
        $display("Mixed %0d source transactions into %0d results across %0d register settings,",
                 sb.sources, sb.mixes, sb.settings);
        $display("including saturated frames, muted and blended channels, and all formats.");
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
